/* rtl/rva_pkg.sv */
// rva_pkg: shared widths, constants, tables and types of the axis-angle rotation core
// no dependencies; imported by rva_build and rotate_vector_about_axis_core
`timescale 1ns / 1ps
`default_nettype none

package rva_pkg;

    // coordinate and matrix formats
    localparam int COORD_W          = 32;
    localparam int MATRIX_FRAC_BITS = 14;
    localparam int MAT_W            = MATRIX_FRAC_BITS + 2;
    localparam int MAT_SH           = 30 - MATRIX_FRAC_BITS;

    // configuration port
    localparam int ANGLE_W    = 17;
    localparam int AXIS_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // matrix builder arithmetic
    localparam int CORDIC_STEPS = 16;
    localparam int Q30_W        = 34;
    localparam int PROD_W       = 2 * Q30_W;
    localparam int ACC_W        = 36;
    localparam int DEG_TURN     = 36000;
    localparam int DEG_HALF     = 18000;

    localparam logic signed [Q30_W-1:0] CORDIC_GAIN_INV = Q30_W'(652032874);
    localparam logic signed [Q30_W-1:0] Q30_ONE         = Q30_W'(1) << 30;
    localparam logic signed [MAT_W-1:0] MAT_ONE         = MAT_W'(1) << MATRIX_FRAC_BITS;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE  = 2'd0,
        REG_AXIS_X = 2'd1,
        REG_AXIS_Y = 2'd2,
        REG_AXIS_Z = 2'd3
    } t_reg_idx;

    // matrix entry and row-major matrix
    typedef logic signed [MAT_W-1:0] t_mentry;
    typedef t_mentry [8:0] t_matrix;

    // arctangent of 2^-i as a binary angle, 2^32 per turn
    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // identity matrix
    function automatic t_matrix mat_identity();
        t_matrix m;
        for (int k = 0; k < 9; k++) begin
            m[k] = (k % 4 == 0) ? MAT_ONE : '0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/rva_build.sv */
// rva_build: configuration registers and the sequencer that rebuilds the rotation matrix
// uses rva_pkg; one shared multiplier, a restoring divider for the unit axis, a reciprocal
// scaling of the angle, a square root and a cordic
`timescale 1ns / 1ps
`default_nettype none

module rva_build import rva_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output t_matrix               o_mat
);

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 62;
    localparam int DVD_W      = 62;
    localparam int CNT_W      = 6;

    localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(1) << 29;
    localparam logic signed [ACC_W:0]    RNDM  = (ACC_W+1)'(1) << (MAT_SH - 1);

    // binary angle of r hundredths: r*BAM_STEP + (r*BAM_REM + half turn) / full turn,
    // the last divide done as (x >> 5) / 1125 by a reciprocal multiply
    localparam logic [31:0] BAM_STEP   = 32'd119304;
    localparam logic [29:0] BAM_REM    = 30'd23296;
    localparam logic [25:0] BAM_RCP    = 26'd61083980;
    localparam int          BAM_RCP_SH = 36;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_MUL, S_SQ_ADD, S_SQ_CHK, S_SQRT, S_DIV_LOAD, S_DIV, S_DIV_END,
        S_ANG_MOD, S_BAM_MUL, S_BAM_SUM, S_CORD_INIT, S_CORD, S_CORD_END,
        S_M_UU, S_M_RND1, S_M_T, S_M_RND2, S_M_S, S_M_RND3, S_M_WR
    } t_state;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] sel;
        logic       neg;
        logic       diag;
    } t_entry_ctl;

    // per-entry operand selection of the rodrigues formula
    function automatic t_entry_ctl entry_ctl(input logic [3:0] k);
        t_entry_ctl c;
        unique case (k)
            4'd0:    c = '{row: 2'd0, col: 2'd0, sel: 2'd0, neg: 1'b0, diag: 1'b1};
            4'd1:    c = '{row: 2'd0, col: 2'd1, sel: 2'd2, neg: 1'b1, diag: 1'b0};
            4'd2:    c = '{row: 2'd0, col: 2'd2, sel: 2'd1, neg: 1'b0, diag: 1'b0};
            4'd3:    c = '{row: 2'd1, col: 2'd0, sel: 2'd2, neg: 1'b0, diag: 1'b0};
            4'd4:    c = '{row: 2'd1, col: 2'd1, sel: 2'd0, neg: 1'b0, diag: 1'b1};
            4'd5:    c = '{row: 2'd1, col: 2'd2, sel: 2'd0, neg: 1'b1, diag: 1'b0};
            4'd6:    c = '{row: 2'd2, col: 2'd0, sel: 2'd1, neg: 1'b1, diag: 1'b0};
            4'd7:    c = '{row: 2'd2, col: 2'd1, sel: 2'd0, neg: 1'b0, diag: 1'b0};
            4'd8:    c = '{row: 2'd2, col: 2'd2, sel: 2'd0, neg: 1'b0, diag: 1'b1};
            default: c = '{row: 2'd0, col: 2'd0, sel: 2'd0, neg: 1'b0, diag: 1'b1};
        endcase
        return c;
    endfunction

    t_state                      r_state;
    logic [3:0]                  r_k;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [ANGLE_W-1:0]   r_angle;
    logic signed [AXIS_W-1:0]    r_axis [3];
    t_matrix                     r_mat;

    logic signed [PROD_W-1:0]    r_prod;
    logic [63:0]                 r_sum;
    logic [63:0]                 r_res;
    logic [63:0]                 r_bit;
    logic [31:0]                 r_len;
    logic [DVD_W-1:0]            r_dvd;
    logic [31:0]                 r_dsr;
    logic [32:0]                 r_rem;
    logic [31:0]                 r_quo;
    logic signed [Q30_W-1:0]     r_u [3];
    logic signed [ANGLE_W:0]     r_ang;
    logic [29:0]                 r_bx;
    logic [31:0]                 r_bhi;
    logic [14:0]                 r_bq;
    logic [31:0]                 r_bam;
    logic signed [Q30_W-1:0]     r_cx, r_cy, r_cz;
    logic                        r_flip;
    logic signed [Q30_W-1:0]     r_c, r_s, r_t;
    logic signed [ACC_W-1:0]     r_acc;

    t_entry_ctl                  w_ctl;
    logic signed [Q30_W-1:0]     w_op_a, w_op_b;
    logic signed [PROD_W-1:0]    w_prod_r;
    logic signed [ACC_W-1:0]     w_rnd;
    logic [31:0]                 w_mag;
    logic [63:0]                 w_rb;
    logic [32:0]                 w_rs;
    logic                        w_dge;
    logic [50:0]                 w_bam_p;
    logic signed [Q30_W-1:0]     w_dx, w_dy, w_atan, w_c, w_s;
    logic signed [31:0]          w_z32;
    logic signed [ACC_W:0]       w_tm_sum;
    logic signed [ACC_W-MAT_SH:0] w_tm_v;
    t_mentry                     w_tm;

    assign w_ctl  = entry_ctl(r_k);
    assign o_busy = (r_state != S_IDLE);
    assign o_mat  = r_mat;

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_SQ_MUL: begin
                w_op_a = Q30_W'(r_axis[r_k[1:0]]);
                w_op_b = Q30_W'(r_axis[r_k[1:0]]);
            end
            S_M_UU: begin
                w_op_a = r_u[w_ctl.row];
                w_op_b = r_u[w_ctl.col];
            end
            S_M_T: begin
                w_op_a = Q30_W'(r_acc);
                w_op_b = r_t;
            end
            S_M_S: begin
                w_op_a = r_u[w_ctl.sel];
                w_op_b = r_s;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // q30 product rounded half up
    assign w_prod_r = r_prod + RND30;
    assign w_rnd    = $signed(w_prod_r[ACC_W+29:30]);

    // axis magnitude for the unit-vector divide
    assign w_mag = r_axis[r_k[1:0]][AXIS_W-1] ? 32'(-r_axis[r_k[1:0]])
                                               : 32'(r_axis[r_k[1:0]]);

    // square root and divider steps
    assign w_rb  = r_res + r_bit;
    assign w_rs  = {r_rem[31:0], r_dvd[DVD_W-1]};
    assign w_dge = (w_rs >= {1'b0, r_dsr});

    // reciprocal multiply for the fractional part of the binary angle
    assign w_bam_p = 51'(r_bx[29:5]) * 51'(BAM_RCP);

    // cordic step terms
    assign w_dx   = r_cy >>> r_cnt[4:0];
    assign w_dy   = r_cx >>> r_cnt[4:0];
    assign w_atan = $signed(Q30_W'(ATAN_BAM[r_cnt[4:0]]));
    assign w_c    = r_flip ? -r_cx : r_cx;
    assign w_s    = r_flip ? -r_cy : r_cy;
    assign w_z32  = $signed(r_bam);

    // q30 entry to matrix format, rounded and clamped to +-1
    always_comb begin
        w_tm_sum = (ACC_W+1)'(r_acc) + RNDM;
        w_tm_v   = $signed(w_tm_sum[ACC_W:MAT_SH]);
        if (w_tm_v > (ACC_W-MAT_SH+1)'(MAT_ONE)) begin
            w_tm = MAT_ONE;
        end else if (w_tm_v < -(ACC_W-MAT_SH+1)'(MAT_ONE)) begin
            w_tm = -MAT_ONE;
        end else begin
            w_tm = MAT_W'(w_tm_v);
        end
    end

    // control: state, counters, config registers and the matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
            r_angle <= '0;
            r_axis  <= '{AXIS_W'(0), AXIS_W'(0), AXIS_W'(65536)};
            r_mat   <= mat_identity();
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ANGLE:  r_angle   <= $signed(i_cfg_data[ANGLE_W-1:0]);
                REG_AXIS_X: r_axis[0] <= $signed(i_cfg_data[AXIS_W-1:0]);
                REG_AXIS_Y: r_axis[1] <= $signed(i_cfg_data[AXIS_W-1:0]);
                REG_AXIS_Z: r_axis[2] <= $signed(i_cfg_data[AXIS_W-1:0]);
                default:    r_angle   <= r_angle;
            endcase
            r_state <= S_SQ_MUL;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: r_state <= S_IDLE;
                S_SQ_MUL: r_state <= S_SQ_ADD;
                S_SQ_ADD: begin
                    r_k     <= r_k + 4'd1;
                    r_state <= (r_k == 4'd2) ? S_SQ_CHK : S_SQ_MUL;
                end
                S_SQ_CHK: begin
                    r_cnt <= '0;
                    if (r_sum == '0) begin
                        r_mat   <= mat_identity();
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_k     <= '0;
                        r_state <= S_DIV_LOAD;
                    end
                end
                S_DIV_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    r_k     <= r_k + 4'd1;
                    r_state <= (r_k == 4'd2) ? S_ANG_MOD : S_DIV_LOAD;
                end
                S_ANG_MOD: begin
                    if (r_ang >= 0 && r_ang < (ANGLE_W+1)'(DEG_TURN)) begin
                        r_state <= S_BAM_MUL;
                    end
                end
                S_BAM_MUL: r_state <= S_BAM_SUM;
                S_BAM_SUM: r_state <= S_CORD_INIT;
                S_CORD_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_CORD_END;
                    end
                end
                S_CORD_END: begin
                    r_k     <= '0;
                    r_state <= S_M_UU;
                end
                S_M_UU:   r_state <= S_M_RND1;
                S_M_RND1: r_state <= S_M_T;
                S_M_T:    r_state <= S_M_RND2;
                S_M_RND2: r_state <= w_ctl.diag ? S_M_WR : S_M_S;
                S_M_S:    r_state <= S_M_RND3;
                S_M_RND3: r_state <= S_M_WR;
                S_M_WR: begin
                    r_mat[r_k] <= w_tm;
                    r_k        <= r_k + 4'd1;
                    r_state    <= (r_k == 4'd8) ? S_IDLE : S_M_UU;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= w_op_a * w_op_b;
        unique case (r_state)
            S_SQ_ADD: r_sum <= r_sum + r_prod[63:0];
            S_SQ_CHK: begin
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            S_SQRT: begin
                if (r_sum >= w_rb) begin
                    r_sum <= r_sum - w_rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DIV_LOAD: begin
                r_len <= r_res[31:0];
                r_dvd <= {w_mag, 30'b0};
                r_dsr <= r_res[31:0];
                r_rem <= '0;
                r_quo <= '0;
            end
            S_DIV: begin
                r_rem <= w_dge ? (w_rs - {1'b0, r_dsr}) : w_rs;
                r_quo <= {r_quo[30:0], w_dge};
                r_dvd <= r_dvd << 1;
            end
            S_DIV_END: begin
                r_u[r_k[1:0]] <= r_axis[r_k[1:0]][AXIS_W-1] ? -Q30_W'(r_quo)
                                                           : Q30_W'(r_quo);
                r_ang <= (ANGLE_W+1)'(r_angle);
                r_dsr <= r_len;
            end
            S_ANG_MOD: begin
                if (r_ang < 0) begin
                    r_ang <= r_ang + (ANGLE_W+1)'(DEG_TURN);
                end else if (r_ang >= (ANGLE_W+1)'(DEG_TURN)) begin
                    r_ang <= r_ang - (ANGLE_W+1)'(DEG_TURN);
                end else begin
                    r_bx  <= 30'(r_ang[15:0]) * BAM_REM + 30'(DEG_HALF);
                    r_bhi <= 32'(r_ang[15:0]) * BAM_STEP;
                end
            end
            S_BAM_MUL: r_bq  <= w_bam_p[50:BAM_RCP_SH];
            S_BAM_SUM: r_bam <= r_bhi + 32'(r_bq);
            S_CORD_INIT: begin
                r_cx <= CORDIC_GAIN_INV;
                r_cy <= '0;
                if (w_z32 > 32'sd1073741824) begin
                    r_cz   <= Q30_W'(w_z32) - (Q30_W'(1) << 31);
                    r_flip <= 1'b1;
                end else if (w_z32 < -32'sd1073741824) begin
                    r_cz   <= Q30_W'(w_z32) + (Q30_W'(1) << 31);
                    r_flip <= 1'b1;
                end else begin
                    r_cz   <= Q30_W'(w_z32);
                    r_flip <= 1'b0;
                end
            end
            S_CORD: begin
                if (!r_cz[Q30_W-1]) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + w_atan;
                end
            end
            S_CORD_END: begin
                r_c <= w_c;
                r_s <= w_s;
                r_t <= Q30_ONE - w_c;
            end
            S_M_RND1: r_acc <= w_rnd;
            S_M_RND2: r_acc <= w_ctl.diag ? (w_rnd + ACC_W'(r_c)) : w_rnd;
            S_M_RND3: r_acc <= w_ctl.neg ? (r_acc - w_rnd) : (r_acc + w_rnd);
            default:  r_acc <= r_acc;
        endcase
        // a fresh build starts its sum of squares from zero
        if (i_cfg_we) begin
            r_sum <= '0;
        end
    end

endmodule

`default_nettype wire

/* rtl/rotate_vector_about_axis_core.sv */
// rotate_vector_about_axis_core: top level, point pipeline applying the rotation matrix
// uses rva_pkg and rva_build (configuration registers and matrix builder)
//
// usage
// - input channel i_in_valid / o_in_stall carries one point (Q16.16 x, y, z) per
//   transaction; output channel o_out_valid / i_out_stall carries the rotated point
//   and a clipped flag that is set when any coordinate saturated
// - throughput is one point per cycle unless i_out_stall or a build holds it; each
//   point passes input register, nine multiplies, rounded row sums and saturation
// - a write on i_cfg_we / i_cfg_idx / i_cfg_data sets the angle (hundredths of a
//   degree) or an axis component and restarts the matrix build; o_in_stall stays high
//   for the build: a 32-step square root, three 62-step divides and a 16-step cordic
//   run one after another, and one multiplier serves the sum of squares and the matrix
//   entries; a zero axis ends the build after the sum of squares with the identity
// - reset loads angle 0, axis (0,0,1) and the identity matrix; no build runs after it
// - when i_out_stall is high with a result waiting, the whole pipeline holds and
//   o_in_stall goes high; nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module rotate_vector_about_axis_core import rva_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COORD_W-1:0] i_in_x,
    input  logic signed [COORD_W-1:0] i_in_y,
    input  logic signed [COORD_W-1:0] i_in_z,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic signed [COORD_W-1:0] o_out_z,
    output logic                      o_clipped
);

    localparam int P_W = COORD_W + MAT_W;
    localparam int S_W = P_W + 2;
    localparam int R_W = S_W - MATRIX_FRAC_BITS;

    localparam logic signed [S_W-1:0] RND_HALF = S_W'(1) << (MATRIX_FRAC_BITS - 1);

    logic                      w_busy;
    t_matrix                   w_mat;
    logic                      w_en;

    logic                      r_v1, r_v2, r_v3, r_vo;
    logic signed [COORD_W-1:0] r_pt [3];
    logic signed [P_W-1:0]     r_p2 [9];
    logic signed [R_W-1:0]     r_s3 [3];
    logic signed [COORD_W-1:0] r_out [3];
    logic                      r_clip;

    logic signed [S_W-1:0]     w_sum [3];
    logic signed [COORD_W-1:0] w_sat [3];
    logic [2:0]                w_ovf;

    // matrix builder and configuration registers
    rva_build u_build (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (w_busy),
        .o_mat      (w_mat)
    );

    // pipeline advances unless a result is waiting on a stalled receiver
    assign w_en       = !(r_vo && i_out_stall);
    assign o_in_stall = !w_en || w_busy;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid && !w_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    // row sums with half-up rounding
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = S_W'(r_p2[3*i]) + S_W'(r_p2[3*i+1]) + S_W'(r_p2[3*i+2]) + RND_HALF;
        end
    end

    // saturation to the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ovf[i] = (r_s3[i][R_W-1:COORD_W-1] != '0) && (r_s3[i][R_W-1:COORD_W-1] != '1);
            if (w_ovf[i]) begin
                w_sat[i] = r_s3[i][R_W-1] ? COORD_MIN : COORD_MAX;
            end else begin
                w_sat[i] = COORD_W'(r_s3[i]);
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pt[0] <= i_in_x;
            r_pt[1] <= i_in_y;
            r_pt[2] <= i_in_z;
            for (int k = 0; k < 9; k++) begin
                r_p2[k] <= $signed(w_mat[k]) * r_pt[k % 3];
            end
            for (int i = 0; i < 3; i++) begin
                r_s3[i]  <= $signed(w_sum[i][S_W-1:MATRIX_FRAC_BITS]);
                r_out[i] <= w_sat[i];
            end
            r_clip <= |w_ovf;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_clipped   = r_clip;

    // a clipped transaction has at least one coordinate at a bound
    a_clip_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_out_x == COORD_MAX || o_out_x == COORD_MIN ||
             o_out_y == COORD_MAX || o_out_y == COORD_MIN ||
             o_out_z == COORD_MAX || o_out_z == COORD_MIN))
        else $error("clipped set with no saturated coordinate");

    // reset leaves the identity matrix
    a_reset_identity: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_mat[0] == MAT_ONE && w_mat[4] == MAT_ONE && w_mat[8] == MAT_ONE &&
                      w_mat[1] == '0 && w_mat[5] == '0 && w_mat[6] == '0))
        else $error("matrix not identity after reset");

    // every register write starts a rebuild
    a_write_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_busy)
        else $error("register write did not start a matrix build");

    // no transaction enters while the matrix is being rebuilt
    a_no_entry_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy && w_en) |=> !r_v1)
        else $error("point entered the pipeline during a matrix build");

endmodule

`default_nettype wire
